// ===== src/dpbb_pkg.sv =====
// Shared types and constants for the dark pixel bounding box block.
package dpbb_pkg;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH    = 2'd0,
      CSR_FRAME_HEIGHT   = 2'd1,
      CSR_COLOR_MODE     = 2'd2,
      CSR_DARK_THRESHOLD = 2'd3
   } csr_index_type;

   // Luma weights in 16-bit-fraction fixed point; they sum to 65536.
   localparam logic [15:0] W_RED   = 16'd19595;
   localparam logic [15:0] W_GREEN = 16'd38470;
   localparam logic [15:0] W_BLUE  = 16'd7471;

   // Register reset values.
   localparam logic [12:0] FRAME_WIDTH_RESET    = 13'd4096;
   localparam logic [12:0] FRAME_HEIGHT_RESET   = 13'd4096;
   localparam logic        COLOR_MODE_RESET     = 1'b1;
   localparam logic [7:0]  DARK_THRESHOLD_RESET = 8'd75;

endpackage

// ===== src/dark_pixel_bounding_box.sv =====
// Dark pixel bounding box: tracks the extent of dark pixels over one raster frame.
//
// Pixels of a frame enter in raster order on the req_ channel, one beat per pixel
// (red in bits 7:0, green in 15:8, blue in 23:16). Each pixel is reduced to a
// gray value (red alone, or the weighted RGB sum) and compared with the dark
// threshold; dark pixels widen the tracked column and row bounds.
// After the last pixel of a frame one beat leaves on the rsp_ channel with the
// found flag, the top-left corner and the crop size (all zero if nothing was
// dark); the tracking state then clears for the next frame.
// The frame size, color mode and threshold are written on the csr_ port; the
// user must write them only while the block is idle, as the block does not
// enforce it. Sizes of 0 act as 1, sizes above MAX_DIM act as MAX_DIM.
// Throughput is one pixel per cycle unless a blocked frame end drops req_tready;
// the gray weighting, the bound update and the result are each registered.
// If the receiver stalls, the pending result holds and pixels keep flowing
// until the next frame end reaches the bound stage; only then does req_tready
// drop. Reset (synchronous) restores the register defaults and empties the
// pipeline and the result register.
module dark_pixel_bounding_box #(
   parameter int MAX_DIM = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red, green, blue
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // found, left, top, crop_width, crop_height
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

   // Configuration registers.
   logic [12:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic        color_mode_ff;
   logic [7:0]  dark_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= dpbb_pkg::FRAME_WIDTH_RESET;
         frame_height_ff   <= dpbb_pkg::FRAME_HEIGHT_RESET;
         color_mode_ff     <= dpbb_pkg::COLOR_MODE_RESET;
         dark_threshold_ff <= dpbb_pkg::DARK_THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         unique case (dpbb_pkg::csr_index_type'(csr_index))
            dpbb_pkg::CSR_FRAME_WIDTH:    frame_width_ff    <= csr_wdata;
            dpbb_pkg::CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata;
            dpbb_pkg::CSR_COLOR_MODE:     color_mode_ff     <= csr_wdata[0];
            dpbb_pkg::CSR_DARK_THRESHOLD: dark_threshold_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Last column and row index after clamping the size to 1..MAX_DIM.
   logic [CW-1:0] last_column;
   logic [CW-1:0] last_row;

   always_comb begin
      if (frame_width_ff == '0) begin
         last_column = '0;
      end else if (32'(frame_width_ff) > MAX_DIM) begin
         last_column = CW'(MAX_DIM - 1);
      end else begin
         last_column = CW'(frame_width_ff - 13'd1);
      end
      if (frame_height_ff == '0) begin
         last_row = '0;
      end else if (32'(frame_height_ff) > MAX_DIM) begin
         last_row = CW'(MAX_DIM - 1);
      end else begin
         last_row = CW'(frame_height_ff - 13'd1);
      end
   end

   // Pipeline control.
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic req_accept;
   logic stall_s2;
   logic s1_move;
   logic s2_fire;
   logic col_last;
   logic row_last;
   logic frame_end;

   // Stage 1: pixel register.
   logic [7:0] red_ff;
   logic [7:0] green_ff;
   logic [7:0] blue_ff;

   // Stage 2: dark flag register.
   logic s2_dark_ff;

   // Frame tracking state.
   logic [CW-1:0] column_ff, column_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] min_col_ff, min_col_in;
   logic [CW-1:0] max_col_ff, max_col_in;
   logic [CW-1:0] min_row_ff, min_row_in;
   logic [CW-1:0] max_row_ff, max_row_in;
   logic          any_dark_ff, any_dark_in;

   // Gray value and threshold test on the stage 1 pixel.
   logic [23:0] gray_sum;
   logic [7:0]  gray;
   logic        s1_dark;

   assign gray_sum = 24'(dpbb_pkg::W_RED)   * 24'(red_ff)
                   + 24'(dpbb_pkg::W_GREEN) * 24'(green_ff)
                   + 24'(dpbb_pkg::W_BLUE)  * 24'(blue_ff);
   assign gray     = color_mode_ff ? gray_sum[23:16] : red_ff;
   assign s1_dark  = gray < dark_threshold_ff;

   assign col_last  = column_ff >= last_column;
   assign row_last  = row_ff >= last_row;
   assign frame_end = col_last && row_last;

   // Only a frame-end pixel meeting a result that has not been taken must wait.
   assign stall_s2    = s2_valid_ff && frame_end && rsp_tvalid_ff && !rsp_tready;
   assign s2_fire     = s2_valid_ff && !stall_s2;
   assign s1_move     = s1_valid_ff && !stall_s2;
   assign req_tready  = !s1_valid_ff || !stall_s2;
   assign req_accept  = req_tvalid && req_tready;

   assign s1_valid_in = req_accept || (s1_valid_ff && stall_s2);
   assign s2_valid_in = s1_move || (s2_valid_ff && stall_s2);

   // Bounds including the stage 2 pixel.
   logic          upd;
   logic [CW-1:0] nxt_min_col;
   logic [CW-1:0] nxt_max_col;
   logic [CW-1:0] nxt_min_row;
   logic [CW-1:0] nxt_max_row;
   logic          nxt_any;

   assign upd         = s2_dark_ff;
   assign nxt_min_col = (upd && column_ff < min_col_ff) ? column_ff : min_col_ff;
   assign nxt_max_col = (upd && column_ff > max_col_ff) ? column_ff : max_col_ff;
   assign nxt_min_row = (upd && row_ff < min_row_ff) ? row_ff : min_row_ff;
   assign nxt_max_row = (upd && row_ff > max_row_ff) ? row_ff : max_row_ff;
   assign nxt_any     = any_dark_ff || upd;

   always_comb begin
      column_in   = column_ff;
      row_in      = row_ff;
      min_col_in  = min_col_ff;
      max_col_in  = max_col_ff;
      min_row_in  = min_row_ff;
      max_row_in  = max_row_ff;
      any_dark_in = any_dark_ff;
      if (s2_fire) begin
         if (frame_end) begin
            column_in   = '0;
            row_in      = '0;
            min_col_in  = CW'(MAX_DIM - 1);
            max_col_in  = '0;
            min_row_in  = CW'(MAX_DIM - 1);
            max_row_in  = '0;
            any_dark_in = 1'b0;
         end else begin
            min_col_in  = nxt_min_col;
            max_col_in  = nxt_max_col;
            min_row_in  = nxt_min_row;
            max_row_in  = nxt_max_row;
            any_dark_in = nxt_any;
            if (col_last) begin
               column_in = '0;
               row_in    = CW'(row_ff + 1'b1);
            end else begin
               column_in = CW'(column_ff + 1'b1);
            end
         end
      end
   end

   // Result fields.
   logic [CW:0]   crop_w_full;
   logic [CW:0]   crop_h_full;
   logic [31:0]   left_wide;
   logic [31:0]   top_wide;
   logic [31:0]   crop_w_wide;
   logic [31:0]   crop_h_wide;
   logic          res_found;
   logic [11:0]   res_left;
   logic [11:0]   res_top;
   logic [12:0]   res_crop_w;
   logic [12:0]   res_crop_h;

   assign crop_w_full = {1'b0, nxt_max_col} - {1'b0, nxt_min_col} + 1'b1;
   assign crop_h_full = {1'b0, nxt_max_row} - {1'b0, nxt_min_row} + 1'b1;
   assign left_wide   = 32'(nxt_min_col);
   assign top_wide    = 32'(nxt_min_row);
   assign crop_w_wide = 32'(crop_w_full);
   assign crop_h_wide = 32'(crop_h_full);
   assign res_found   = nxt_any;
   assign res_left    = nxt_any ? left_wide[11:0]   : '0;
   assign res_top     = nxt_any ? top_wide[11:0]    : '0;
   assign res_crop_w  = nxt_any ? crop_w_wide[12:0] : '0;
   assign res_crop_h  = nxt_any ? crop_h_wide[12:0] : '0;

   always_comb begin
      if (s2_fire && frame_end) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   logic [55:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         column_ff     <= '0;
         row_ff        <= '0;
         min_col_ff    <= CW'(MAX_DIM - 1);
         max_col_ff    <= '0;
         min_row_ff    <= CW'(MAX_DIM - 1);
         max_row_ff    <= '0;
         any_dark_ff   <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         min_col_ff    <= min_col_in;
         max_col_ff    <= max_col_in;
         min_row_ff    <= min_row_in;
         max_row_ff    <= max_row_in;
         any_dark_ff   <= any_dark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         red_ff   <= req_tdata[7:0];
         green_ff <= req_tdata[15:8];
         blue_ff  <= req_tdata[23:16];
      end
      if (s1_move) begin
         s2_dark_ff <= s1_dark;
      end
      if (s2_fire && frame_end) begin
         rsp_data_ff <= {5'd0, res_crop_h, res_crop_w, res_top, res_left, res_found};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // Bounds are ordered whenever a dark pixel has been seen.
   assert property (@(posedge clock) disable iff (reset)
      any_dark_ff |-> (min_col_ff <= max_col_ff && min_row_ff <= max_row_ff))
      else $error("bounds out of order with dark pixels seen");

   // Without a dark pixel the bounds keep their cleared values.
   assert property (@(posedge clock) disable iff (reset)
      !any_dark_ff |-> (min_col_ff == CW'(MAX_DIM - 1) && max_col_ff == '0
                        && min_row_ff == CW'(MAX_DIM - 1) && max_row_ff == '0))
      else $error("bounds moved without a dark pixel");

   // Back-pressure on the input only comes from a blocked frame end.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s2_valid_ff && rsp_tvalid_ff && frame_end))
      else $error("input stalled without a blocked frame end");

   // A frame end clears the tracking state.
   assert property (@(posedge clock) disable iff (reset)
      (s2_fire && frame_end) |=> (column_ff == '0 && row_ff == '0 && !any_dark_ff))
      else $error("state not cleared after frame end");

   // A new result only appears after a frame end was processed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(s2_fire && frame_end))
      else $error("result raised without a frame end");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the dark pixel bounding box block.
`timescale 1ns / 100ps

module tb_top;

   localparam int MAX_DIM     = 4096;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [23:0] WHITE = 24'hFFFFFF;
   localparam logic [23:0] BLACK = 24'h000000;

   typedef struct packed {
      logic        found;
      logic [11:0] left;
      logic [11:0] top;
      logic [12:0] crop_w;
      logic [12:0] crop_h;
   } box_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // red, green, blue
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // found, left, top, crop_width, crop_height
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_wdata = '0;

   // Pixels waiting to be driven and boxes waiting to come out.
   logic [23:0] pixel_q[$];
   box_type     box_q[$];

   int send_idle_pct = 18;
   int recv_idle_pct = 51;
   int mismatch_count = 0;
   int cycle_count = 0;

   // Shadow of the block: registers and frame tracking state.
   logic [12:0] cfg_width  = dpbb_pkg::FRAME_WIDTH_RESET;
   logic [12:0] cfg_height = dpbb_pkg::FRAME_HEIGHT_RESET;
   logic        cfg_mode   = dpbb_pkg::COLOR_MODE_RESET;
   logic [7:0]  cfg_thresh = dpbb_pkg::DARK_THRESHOLD_RESET;
   int unsigned pos_col = 0, pos_row = 0;
   int unsigned lo_col = MAX_DIM - 1, hi_col = 0;
   int unsigned lo_row = MAX_DIM - 1, hi_row = 0;
   logic        seen_dark = 1'b0;

   dark_pixel_bounding_box #(.MAX_DIM(MAX_DIM)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int unsigned dim_limit(logic [12:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
   endfunction

   // Number of beats that finish the current frame from the tracked position.
   function automatic int unsigned pixels_left();
      int unsigned w, h, n;
      w = dim_limit(cfg_width);
      h = dim_limit(cfg_height);
      n = (pos_col + 1 < w) ? w - pos_col : 1;
      if (pos_row + 1 < h) n += (h - pos_row - 1) * w;
      return n;
   endfunction

   task automatic clear_bounds();
      pos_col = 0;
      pos_row = 0;
      lo_col = MAX_DIM - 1;
      hi_col = 0;
      lo_row = MAX_DIM - 1;
      hi_row = 0;
      seen_dark = 1'b0;
   endtask

   // Updates the bounds with one accepted pixel and queues a box at frame end.
   task automatic track_pixel(input logic [23:0] px);
      int unsigned gray, w, h;
      box_type box;
      w = dim_limit(cfg_width);
      h = dim_limit(cfg_height);
      if (cfg_mode)
         gray = (int'(dpbb_pkg::W_RED) * int'(px[7:0])
                 + int'(dpbb_pkg::W_GREEN) * int'(px[15:8])
                 + int'(dpbb_pkg::W_BLUE) * int'(px[23:16])) >> 16;
      else
         gray = 32'(px[7:0]);
      if (gray < cfg_thresh) begin
         if (pos_col < lo_col) lo_col = pos_col;
         if (pos_col > hi_col) hi_col = pos_col;
         if (pos_row < lo_row) lo_row = pos_row;
         if (pos_row > hi_row) hi_row = pos_row;
         seen_dark = 1'b1;
      end
      if (pos_col + 1 < w) begin
         pos_col++;
      end else begin
         pos_col = 0;
         if (pos_row + 1 < h) begin
            pos_row++;
         end else begin
            box = '0;
            if (seen_dark) begin
               box.found  = 1'b1;
               box.left   = lo_col[11:0];
               box.top    = lo_row[11:0];
               box.crop_w = 13'(hi_col - lo_col + 1);
               box.crop_h = 13'(hi_row - lo_row + 1);
            end
            box_q.push_back(box);
            clear_bounds();
         end
      end
   endtask

   // Pixel driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) track_pixel(req_tdata);
         if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= pixel_q.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   task automatic report(string field, int unsigned want, int unsigned got);
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   // Result monitor.
   always @(posedge clock) begin
      box_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (box_q.size() == 0) begin
               $display("%0t: expected no result beat, got %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = box_q.pop_front();
               if (rsp_tdata[0] !== want.found)
                  report("found", 32'(want.found), 32'(rsp_tdata[0]));
               if (rsp_tdata[12:1] !== want.left)
                  report("left", 32'(want.left), 32'(rsp_tdata[12:1]));
               if (rsp_tdata[24:13] !== want.top)
                  report("top", 32'(want.top), 32'(rsp_tdata[24:13]));
               if (rsp_tdata[37:25] !== want.crop_w)
                  report("crop_width", 32'(want.crop_w), 32'(rsp_tdata[37:25]));
               if (rsp_tdata[50:38] !== want.crop_h)
                  report("crop_height", 32'(want.crop_h), 32'(rsp_tdata[50:38]));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_csr(dpbb_pkg::csr_index_type idx, logic [12:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         dpbb_pkg::CSR_FRAME_WIDTH:    cfg_width  = value;
         dpbb_pkg::CSR_FRAME_HEIGHT:   cfg_height = value;
         dpbb_pkg::CSR_COLOR_MODE:     cfg_mode   = value[0];
         dpbb_pkg::CSR_DARK_THRESHOLD: cfg_thresh = value[7:0];
         default: ;
      endcase
   endtask

   // Waits until every pixel is accepted and every box has come out, then lets
   // a pixel still inside the pipeline drain.
   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_q.size() != 0 || req_tvalid || box_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_run(int unsigned n, logic [23:0] px);
      repeat (n) pixel_q.push_back(px);
   endtask

   function automatic logic [23:0] random_pixel();
      logic [7:0] lim;
      lim = cfg_thresh;
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return {8'($urandom_range(lim, 0)), 8'($urandom_range(lim, 0)),
                    8'($urandom_range(lim, 0))};
         default: return {8'($urandom_range(255, lim)), 8'($urandom_range(255, lim)),
                          8'($urandom_range(255, lim))};
      endcase
   endfunction

   function automatic logic [12:0] random_dim(int unsigned top);
      case ($urandom_range(9))
         0: return 13'd0;
         1: return 13'($urandom_range(top * 3, top + 1));
         default: return 13'($urandom_range(top, 1));
      endcase
   endfunction

   initial begin
      int unsigned sent, n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Small frame with the reset color mode and threshold: black, pure red
      // just above the threshold, pure blue, gray at and below the threshold.
      write_csr(dpbb_pkg::CSR_FRAME_WIDTH, 13'd4);
      write_csr(dpbb_pkg::CSR_FRAME_HEIGHT, 13'd3);
      pixel_q.push_back(WHITE);
      pixel_q.push_back(BLACK);
      pixel_q.push_back(24'h0000FF);
      pixel_q.push_back(24'hFF0000);
      pixel_q.push_back(24'h4B4B4B);
      pixel_q.push_back(24'h4A4A4A);
      pixel_q.push_back(24'h00FF00);
      push_run(5, WHITE);
      wait_idle();

      // Threshold zero: nothing can be dark, so the box is all zeros.
      write_csr(dpbb_pkg::CSR_DARK_THRESHOLD, 13'h1F00);
      write_csr(dpbb_pkg::CSR_FRAME_WIDTH, 13'd1);
      write_csr(dpbb_pkg::CSR_FRAME_HEIGHT, 13'd2);
      push_run(2, BLACK);
      wait_idle();

      // Red-only mode with over-wide writes and a zero width acting as one.
      write_csr(dpbb_pkg::CSR_COLOR_MODE, 13'h1FFE);
      write_csr(dpbb_pkg::CSR_DARK_THRESHOLD, 13'h1F80);
      write_csr(dpbb_pkg::CSR_FRAME_WIDTH, 13'd0);
      pixel_q.push_back(24'hFFFF7F);
      pixel_q.push_back(24'h000080);
      wait_idle();

      // Frame size shrinks while a frame is in progress.
      write_csr(dpbb_pkg::CSR_COLOR_MODE, 13'h0003);
      write_csr(dpbb_pkg::CSR_DARK_THRESHOLD, 13'h00FF);
      write_csr(dpbb_pkg::CSR_FRAME_WIDTH, 13'd5);
      write_csr(dpbb_pkg::CSR_FRAME_HEIGHT, 13'd3);
      pixel_q.push_back(WHITE);
      pixel_q.push_back(24'h101010);
      pixel_q.push_back(WHITE);
      wait_idle();
      write_csr(dpbb_pkg::CSR_FRAME_WIDTH, 13'd2);
      push_run(2, 24'h202020);
      wait_idle();
      write_csr(dpbb_pkg::CSR_FRAME_HEIGHT, 13'd1);
      push_run(pixels_left(), 24'h303030);
      wait_idle();

      // Sizes at and above the largest, cut short by a shrink mid-frame.
      write_csr(dpbb_pkg::CSR_DARK_THRESHOLD, 13'd75);
      write_csr(dpbb_pkg::CSR_FRAME_WIDTH, 13'h1FFF);
      write_csr(dpbb_pkg::CSR_FRAME_HEIGHT, 13'd1);
      pixel_q.push_back(WHITE);
      pixel_q.push_back(BLACK);
      push_run(3, WHITE);
      wait_idle();
      write_csr(dpbb_pkg::CSR_FRAME_WIDTH, 13'd3);
      pixel_q.push_back(BLACK);
      wait_idle();
      write_csr(dpbb_pkg::CSR_FRAME_WIDTH, 13'd1);
      write_csr(dpbb_pkg::CSR_FRAME_HEIGHT, 13'd4096);
      push_run(3, WHITE);
      wait_idle();
      write_csr(dpbb_pkg::CSR_FRAME_HEIGHT, 13'd2);
      pixel_q.push_back(BLACK);
      wait_idle();

      write_csr(dpbb_pkg::CSR_FRAME_WIDTH, 13'd6);
      write_csr(dpbb_pkg::CSR_FRAME_HEIGHT, 13'd4);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 51 : 0;
         recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 18 : 0;
         sent = 0;
         while (sent < 290) begin
            if ($urandom_range(1)) write_csr(dpbb_pkg::CSR_FRAME_WIDTH, random_dim(8));
            if ($urandom_range(1)) write_csr(dpbb_pkg::CSR_FRAME_HEIGHT, random_dim(5));
            if ($urandom_range(2) == 0)
               write_csr(dpbb_pkg::CSR_COLOR_MODE, 13'($urandom));
            if ($urandom_range(1)) begin
               case ($urandom_range(4))
                  0: write_csr(dpbb_pkg::CSR_DARK_THRESHOLD, {5'($urandom), 8'd0});
                  1: write_csr(dpbb_pkg::CSR_DARK_THRESHOLD, {5'($urandom), 8'd255});
                  default: write_csr(dpbb_pkg::CSR_DARK_THRESHOLD, 13'($urandom));
               endcase
            end
            // Mostly whole frames; now and then a partial one so that the
            // next size change lands in the middle of a frame.
            n = pixels_left();
            if ($urandom_range(9) == 0) n = $urandom_range(n, 1);
            repeat (n) pixel_q.push_back(random_pixel());
            sent += n;
            wait_idle();
         end
      end

      do @(negedge clock);
      while (pixel_q.size() != 0 || req_tvalid || box_q.size() != 0);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
